// ===== design/las_pkg.sv =====
// Shared widths, register map, reset values and fixed-point constants for the Lorenz step block.
package las_pkg;

    localparam int DEF_SCREEN_WIDTH  = 1920;
    localparam int DEF_SCREEN_HEIGHT = 1080;

    localparam int POS_W     = 32;
    localparam int FRAC_W    = 16;
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int RATE_W    = 50;
    localparam int RATE_LO_W = 25;
    localparam int FULL_W    = 68;
    localparam int INC_W     = FULL_W - FRAC_W;
    localparam int SUM_W     = INC_W + 1;

    localparam int SIGMA_W    = 23;
    localparam int RHO_W      = 24;
    localparam int BETA_W     = 21;
    localparam int STEP_W     = 17;
    localparam int START_W    = 23;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_ADDR_W-1:0] CFG_SIGMA   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RHO     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_BETA    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_X = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_Y = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_Z = 3'd6;

    localparam logic [SIGMA_W-1:0] SIGMA_RST = 23'd655360;
    localparam logic [RHO_W-1:0]   RHO_RST   = 24'd1835008;
    localparam logic [BETA_W-1:0]  BETA_RST  = 21'd174763;
    localparam logic [STEP_W-1:0]  STEP_RST  = 17'd328;
    localparam logic [START_W-1:0] START_RST = 23'd65536;
    localparam logic [POS_W-1:0]   POS_RST   = 32'd65536;

    // pixel mapping: q = ((p + ofs) * 18 * N + bias) >>> shift, pixel = q / div
    localparam int PIX_GAIN  = 18;
    localparam int X_OFS     = 1310720;
    localparam int Y_OFS     = 1966080;
    localparam int COL_BIAS  = 26214400;
    localparam int ROW_BIAS  = 39321600;
    localparam int COL_SHIFT = 21;
    localparam int ROW_SHIFT = 20;
    localparam int COL_DIV   = 25;
    localparam int ROW_DIV   = 75;
    localparam int RECIP_C       = 167773;
    localparam int RECIP_C_SHIFT = 22;
    localparam int RECIP_R       = 447393;
    localparam int RECIP_R_SHIFT = 25;

    typedef struct packed {
        logic        [SIGMA_W-1:0] sigma;
        logic        [RHO_W-1:0]   rho;
        logic        [BETA_W-1:0]  beta;
        logic        [STEP_W-1:0]  step_size;
        logic signed [START_W-1:0] start_x;
        logic signed [START_W-1:0] start_y;
        logic signed [START_W-1:0] start_z;
    } las_cfg_t;

endpackage

// ===== design/lorenz_attractor_step_top.sv =====
// Lorenz trajectory stepper: one Euler step and one screen pixel per input word.
//
// Input channel (s_valid/s_ready, s_restart): each accepted word advances the
// held point by one forward-Euler step; s_restart first reloads the start point.
// Result channel (m_valid/m_ready): new x, y, z in signed Q16.16 (saturated),
// plus column, row and an on-screen flag (cleared when either was clamped).
// Configuration: cfg_wr_en/cfg_addr/cfg_wr_data, one register per write,
// written only while idle, a rule on the user that the block does not enforce.
// Timing: all multiplications go through one shared 33x33 multiplier, fourteen
// passes per word under a step counter. The result appears and s_ready returns
// at the same time, so a new word is taken only after the last one is finished
// and its result has entered the output register.
// The output register holds a finished word while the next one is computed;
// if it is still occupied when that next word completes, the sequencer holds
// in its last step until m_ready frees the register.
// Reset: synchronous, active low; the point returns to (1, 1, 1), the sequencer
// and m_valid clear, and the configuration registers return to their defaults.
module lorenz_attractor_step_top #(
    parameter int SCREEN_WIDTH  = las_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = las_pkg::DEF_SCREEN_HEIGHT,
    localparam int COL_W = $clog2(SCREEN_WIDTH),
    localparam int ROW_W = $clog2(SCREEN_HEIGHT)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_restart,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [las_pkg::POS_W-1:0] m_out_x,
    output logic signed [las_pkg::POS_W-1:0] m_out_y,
    output logic signed [las_pkg::POS_W-1:0] m_out_z,
    output logic [COL_W-1:0]                m_column,
    output logic [ROW_W-1:0]                m_row,
    output logic                            m_on_screen,
    input  logic                            cfg_wr_en,
    input  logic [las_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [las_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
    import las_pkg::*;

    localparam int COL_SCALE = PIX_GAIN * SCREEN_WIDTH;
    localparam int ROW_SCALE = PIX_GAIN * SCREEN_HEIGHT;
    localparam int COL_LIM   = COL_DIV * SCREEN_WIDTH;
    localparam int ROW_LIM   = ROW_DIV * SCREEN_HEIGHT;
    localparam int QC_W      = $clog2(COL_LIM);
    localparam int QR_W      = $clog2(ROW_LIM);
    localparam int COLQ_W    = PROD_W - COL_SHIFT;
    localparam int ROWQ_W    = PROD_W - ROW_SHIFT;
    localparam int ST_W      = 4;

    localparam logic [ST_W-1:0] S_MUL_RX   = 4'd0;
    localparam logic [ST_W-1:0] S_MUL_RY   = 4'd1;
    localparam logic [ST_W-1:0] S_MUL_RZA  = 4'd2;
    localparam logic [ST_W-1:0] S_MUL_RZB  = 4'd3;
    localparam logic [ST_W-1:0] S_MUL_XLO  = 4'd4;
    localparam logic [ST_W-1:0] S_MUL_XHI  = 4'd5;
    localparam logic [ST_W-1:0] S_MUL_YLO  = 4'd6;
    localparam logic [ST_W-1:0] S_MUL_YHI  = 4'd7;
    localparam logic [ST_W-1:0] S_MUL_ZLO  = 4'd8;
    localparam logic [ST_W-1:0] S_MUL_ZHI  = 4'd9;
    localparam logic [ST_W-1:0] S_MUL_COL  = 4'd10;
    localparam logic [ST_W-1:0] S_MUL_ROW  = 4'd11;
    localparam logic [ST_W-1:0] S_MUL_CDIV = 4'd12;
    localparam logic [ST_W-1:0] S_MUL_RDIV = 4'd13;
    localparam logic [ST_W-1:0] S_DONE     = 4'd14;

    las_cfg_t cfg_q;

    logic              busy_reg, busy_next;
    logic [ST_W-1:0]   step_reg, step_next;
    logic signed [POS_W-1:0]  pos_x_reg, pos_x_next;
    logic signed [POS_W-1:0]  pos_y_reg, pos_y_next;
    logic signed [POS_W-1:0]  pos_z_reg, pos_z_next;
    logic signed [RATE_W-1:0] rx_reg, rx_next;
    logic signed [RATE_W-1:0] ry_reg, ry_next;
    logic signed [RATE_W-1:0] rz_reg, rz_next;
    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic [QC_W-1:0]   qc_reg, qc_next;
    logic [QR_W-1:0]   qr_reg, qr_next;
    logic              col_lo_reg, col_lo_next, col_hi_reg, col_hi_next;
    logic              row_lo_reg, row_lo_next, row_hi_reg, row_hi_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic              m_valid_reg, m_valid_next;
    logic signed [POS_W-1:0]  m_out_x_reg, m_out_x_next;
    logic signed [POS_W-1:0]  m_out_y_reg, m_out_y_next;
    logic signed [POS_W-1:0]  m_out_z_reg, m_out_z_next;
    logic [COL_W-1:0]  m_column_reg, m_column_next;
    logic [ROW_W-1:0]  m_row_reg, m_row_next;
    logic              m_on_screen_reg, m_on_screen_next;

    logic                     mul_en;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [RATE_W-1:0] prod_q;
    logic signed [POS_W-1:0]  pos_sel, new_pos;
    logic signed [FULL_W-1:0] full;
    logic signed [INC_W-1:0]  inc;
    logic signed [SUM_W-1:0]  pos_sum;
    logic signed [PROD_W-1:0] pix_t;
    logic [ROW_W-1:0]         row_val;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (&v[SUM_W-1:POS_W-1] || ~|v[SUM_W-1:POS_W-1]) begin
            r = v[POS_W-1:0];
        end else if (v[SUM_W-1]) begin
            r = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(POS_W-1){1'b1}}};
        end
        return r;
    endfunction

    las_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (cfg_wr_en),
        .addr    (cfg_addr),
        .wr_data (cfg_wr_data),
        .cfg     (cfg_q)
    );

    las_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    assign s_ready = !busy_reg;
    assign mul_en  = busy_reg && (step_reg != S_DONE);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            S_MUL_RX: begin
                mul_a = {pos_y_reg[POS_W-1], pos_y_reg} - {pos_x_reg[POS_W-1], pos_x_reg};
                mul_b = {{(MUL_W-SIGMA_W){1'b0}}, cfg_q.sigma};
            end
            S_MUL_RY: begin
                mul_a = {pos_x_reg[POS_W-1], pos_x_reg};
                mul_b = {{(MUL_W-RHO_W){1'b0}}, cfg_q.rho} - {pos_z_reg[POS_W-1], pos_z_reg};
            end
            S_MUL_RZA: begin
                mul_a = {pos_x_reg[POS_W-1], pos_x_reg};
                mul_b = {pos_y_reg[POS_W-1], pos_y_reg};
            end
            S_MUL_RZB: begin
                mul_a = {{(MUL_W-BETA_W){1'b0}}, cfg_q.beta};
                mul_b = {pos_z_reg[POS_W-1], pos_z_reg};
            end
            S_MUL_XLO: begin
                mul_a = {{(MUL_W-RATE_LO_W){1'b0}}, rx_reg[RATE_LO_W-1:0]};
                mul_b = {{(MUL_W-STEP_W){1'b0}}, cfg_q.step_size};
            end
            S_MUL_XHI: begin
                mul_a = {{(MUL_W-RATE_W+RATE_LO_W){rx_reg[RATE_W-1]}},
                         rx_reg[RATE_W-1:RATE_LO_W]};
                mul_b = {{(MUL_W-STEP_W){1'b0}}, cfg_q.step_size};
            end
            S_MUL_YLO: begin
                mul_a = {{(MUL_W-RATE_LO_W){1'b0}}, ry_reg[RATE_LO_W-1:0]};
                mul_b = {{(MUL_W-STEP_W){1'b0}}, cfg_q.step_size};
            end
            S_MUL_YHI: begin
                mul_a = {{(MUL_W-RATE_W+RATE_LO_W){ry_reg[RATE_W-1]}},
                         ry_reg[RATE_W-1:RATE_LO_W]};
                mul_b = {{(MUL_W-STEP_W){1'b0}}, cfg_q.step_size};
            end
            S_MUL_ZLO: begin
                mul_a = {{(MUL_W-RATE_LO_W){1'b0}}, rz_reg[RATE_LO_W-1:0]};
                mul_b = {{(MUL_W-STEP_W){1'b0}}, cfg_q.step_size};
            end
            S_MUL_ZHI: begin
                mul_a = {{(MUL_W-RATE_W+RATE_LO_W){rz_reg[RATE_W-1]}},
                         rz_reg[RATE_W-1:RATE_LO_W]};
                mul_b = {{(MUL_W-STEP_W){1'b0}}, cfg_q.step_size};
            end
            S_MUL_COL: begin
                mul_a = {pos_x_reg[POS_W-1], pos_x_reg} + MUL_W'(X_OFS);
                mul_b = MUL_W'(COL_SCALE);
            end
            S_MUL_ROW: begin
                mul_a = {pos_y_reg[POS_W-1], pos_y_reg} + MUL_W'(Y_OFS);
                mul_b = MUL_W'(ROW_SCALE);
            end
            S_MUL_CDIV: begin
                mul_a = {{(MUL_W-QC_W){1'b0}}, qc_reg};
                mul_b = MUL_W'(RECIP_C);
            end
            S_MUL_RDIV: begin
                mul_a = {{(MUL_W-QR_W){1'b0}}, qr_reg};
                mul_b = MUL_W'(RECIP_R);
            end
            default: ;
        endcase
    end

    // Euler update: (hi partial << 25) + lo partial, floor to Q16.16, saturate
    assign prod_q  = mul_p[PROD_W-1:FRAC_W];
    assign pos_sel = (step_reg == S_MUL_YLO) ? pos_x_reg :
                     (step_reg == S_MUL_ZLO) ? pos_y_reg : pos_z_reg;
    assign full    = ({{(FULL_W-PROD_W){mul_p[PROD_W-1]}}, mul_p} <<< RATE_LO_W)
                   + {{(FULL_W-PROD_W){acc_reg[PROD_W-1]}}, acc_reg};
    assign inc     = full[FULL_W-1:FRAC_W];
    assign pos_sum = {{(SUM_W-POS_W){pos_sel[POS_W-1]}}, pos_sel} + {inc[INC_W-1], inc};
    assign new_pos = sat_pos(pos_sum);
    assign pix_t   = mul_p + ((step_reg == S_MUL_ROW) ? PROD_W'(COL_BIAS) : PROD_W'(ROW_BIAS));
    assign row_val = row_lo_reg ? '0 :
                     row_hi_reg ? ROW_W'(SCREEN_HEIGHT - 1) : mul_p[RECIP_R_SHIFT +: ROW_W];

    always_comb begin
        busy_next        = busy_reg;
        step_next        = step_reg;
        pos_x_next       = pos_x_reg;
        pos_y_next       = pos_y_reg;
        pos_z_next       = pos_z_reg;
        rx_next          = rx_reg;
        ry_next          = ry_reg;
        rz_next          = rz_reg;
        acc_next         = acc_reg;
        qc_next          = qc_reg;
        qr_next          = qr_reg;
        col_lo_next      = col_lo_reg;
        col_hi_next      = col_hi_reg;
        row_lo_next      = row_lo_reg;
        row_hi_next      = row_hi_reg;
        col_next         = col_reg;
        m_valid_next     = m_valid_reg;
        m_out_x_next     = m_out_x_reg;
        m_out_y_next     = m_out_y_reg;
        m_out_z_next     = m_out_z_reg;
        m_column_next    = m_column_reg;
        m_row_next       = m_row_reg;
        m_on_screen_next = m_on_screen_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (!busy_reg) begin
            if (s_valid) begin
                busy_next = 1'b1;
                step_next = S_MUL_RX;
                if (s_restart) begin
                    pos_x_next = {{(POS_W-START_W){cfg_q.start_x[START_W-1]}}, cfg_q.start_x};
                    pos_y_next = {{(POS_W-START_W){cfg_q.start_y[START_W-1]}}, cfg_q.start_y};
                    pos_z_next = {{(POS_W-START_W){cfg_q.start_z[START_W-1]}}, cfg_q.start_z};
                end
            end
        end else begin
            step_next = step_reg + 4'd1;
            // each step takes the product issued in the step before
            case (step_reg)
                S_MUL_RY:  rx_next = prod_q;
                S_MUL_RZA: ry_next = prod_q - {{(RATE_W-POS_W){pos_y_reg[POS_W-1]}}, pos_y_reg};
                S_MUL_RZB: rz_next = prod_q;
                S_MUL_XLO: rz_next = rz_reg - prod_q;
                S_MUL_XHI, S_MUL_YHI, S_MUL_ZHI: acc_next = mul_p;
                S_MUL_YLO: pos_x_next = new_pos;
                S_MUL_ZLO: pos_y_next = new_pos;
                S_MUL_COL: pos_z_next = new_pos;
                S_MUL_ROW: begin
                    col_lo_next = pix_t[PROD_W-1];
                    col_hi_next = !pix_t[PROD_W-1]
                                && (pix_t[PROD_W-1:COL_SHIFT] >= COLQ_W'(COL_LIM));
                    qc_next     = pix_t[COL_SHIFT +: QC_W];
                end
                S_MUL_CDIV: begin
                    row_lo_next = pix_t[PROD_W-1];
                    row_hi_next = !pix_t[PROD_W-1]
                                && (pix_t[PROD_W-1:ROW_SHIFT] >= ROWQ_W'(ROW_LIM));
                    qr_next     = pix_t[ROW_SHIFT +: QR_W];
                end
                S_MUL_RDIV: begin
                    col_next = col_lo_reg ? '0 :
                               col_hi_reg ? COL_W'(SCREEN_WIDTH - 1) :
                                            mul_p[RECIP_C_SHIFT +: COL_W];
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        busy_next        = 1'b0;
                        step_next        = S_MUL_RX;
                        m_valid_next     = 1'b1;
                        m_out_x_next     = pos_x_reg;
                        m_out_y_next     = pos_y_reg;
                        m_out_z_next     = pos_z_reg;
                        m_column_next    = col_reg;
                        m_row_next       = row_val;
                        m_on_screen_next = !(col_lo_reg || col_hi_reg || row_lo_reg || row_hi_reg);
                    end else begin
                        step_next = step_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            step_reg    <= S_MUL_RX;
            m_valid_reg <= 1'b0;
            pos_x_reg   <= POS_RST;
            pos_y_reg   <= POS_RST;
            pos_z_reg   <= POS_RST;
        end else begin
            busy_reg    <= busy_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            pos_z_reg   <= pos_z_next;
        end
    end

    always_ff @(posedge aclk) begin
        rx_reg          <= rx_next;
        ry_reg          <= ry_next;
        rz_reg          <= rz_next;
        acc_reg         <= acc_next;
        qc_reg          <= qc_next;
        qr_reg          <= qr_next;
        col_lo_reg      <= col_lo_next;
        col_hi_reg      <= col_hi_next;
        row_lo_reg      <= row_lo_next;
        row_hi_reg      <= row_hi_next;
        col_reg         <= col_next;
        m_out_x_reg     <= m_out_x_next;
        m_out_y_reg     <= m_out_y_next;
        m_out_z_reg     <= m_out_z_next;
        m_column_reg    <= m_column_next;
        m_row_reg       <= m_row_next;
        m_on_screen_reg <= m_on_screen_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_out_x     = m_out_x_reg;
    assign m_out_y     = m_out_y_reg;
    assign m_out_z     = m_out_z_reg;
    assign m_column    = m_column_reg;
    assign m_row       = m_row_reg;
    assign m_on_screen = m_on_screen_reg;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (busy_reg && step_reg == S_MUL_RX))
        else $error("accepted word did not start the sequence");

    a_result_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(busy_reg) && $past(step_reg) == S_DONE))
        else $error("result raised outside the last step");

    a_restart_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_restart) |=>
        (pos_x_reg == {{(POS_W-START_W){$past(cfg_q.start_x[START_W-1])}},
                       $past(cfg_q.start_x)}))
        else $error("restart did not load the start point");

    a_clamp_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_on_screen_reg) |->
        (m_column_reg == '0 || m_column_reg == COL_W'(SCREEN_WIDTH - 1)
         || m_row_reg == '0 || m_row_reg == ROW_W'(SCREEN_HEIGHT - 1)))
        else $error("off-screen pixel not on the screen border");
`endif

endmodule

// ===== design/las_mul.sv =====
// Shared signed multiplier with registered product.
module las_mul (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [las_pkg::MUL_W-1:0]  a,
    input  logic signed [las_pkg::MUL_W-1:0]  b,
    output logic signed [las_pkg::PROD_W-1:0] p
);
    import las_pkg::*;

    logic signed [PROD_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;

endmodule

// ===== design/las_cfg.sv =====
// Configuration register file: coefficients, time step and start point.
module las_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            wr_en,
    input  logic [las_pkg::CFG_ADDR_W-1:0]  addr,
    input  logic [las_pkg::CFG_DATA_W-1:0]  wr_data,
    output las_pkg::las_cfg_t               cfg
);
    import las_pkg::*;

    las_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sigma     <= SIGMA_RST;
            cfg_reg.rho       <= RHO_RST;
            cfg_reg.beta      <= BETA_RST;
            cfg_reg.step_size <= STEP_RST;
            cfg_reg.start_x   <= START_RST;
            cfg_reg.start_y   <= START_RST;
            cfg_reg.start_z   <= START_RST;
        end else if (wr_en) begin
            case (addr)
                CFG_SIGMA:   cfg_reg.sigma     <= wr_data[SIGMA_W-1:0];
                CFG_RHO:     cfg_reg.rho       <= wr_data[RHO_W-1:0];
                CFG_BETA:    cfg_reg.beta      <= wr_data[BETA_W-1:0];
                CFG_STEP:    cfg_reg.step_size <= wr_data[STEP_W-1:0];
                CFG_START_X: cfg_reg.start_x   <= wr_data[START_W-1:0];
                CFG_START_Y: cfg_reg.start_y   <= wr_data[START_W-1:0];
                CFG_START_Z: cfg_reg.start_z   <= wr_data[START_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
